// ----- hw/rtl/tcw_pkg.sv -----
// Shared types, codes and constants for the text console writer.
package tcw_pkg;

    localparam int CELL_W  = 11;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int NUM_W   = 31;
    localparam int DIGIT_W = 4;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_INT  = 1'b1;

    localparam logic [CHAR_W-1:0] NUL_CODE     = 8'd0;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] ZERO_GLYPH   = 8'd48;

    localparam int START_CELL = 180 + 80 * 12;

    // Reciprocal of ten: (n * RECIP) >> RECIP_SHIFT equals n / 10 for any 32-bit n.
    localparam int RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    typedef struct packed {
        logic              command;
        logic [CHAR_W-1:0] char_code;
        logic [ATTR_W-1:0] attribute;
        logic [NUM_W-1:0]  number;
    } t_in_item;

    typedef struct packed {
        logic [CELL_W-1:0] cell_index;
        logic [CHAR_W-1:0] glyph;
        logic [ATTR_W-1:0] colour;
        logic              last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load_item;
        logic do_newline;
        logic do_mul;
        logic do_div;
        logic load_char_out;
        logic load_digit_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic quot_zero;
        logic count_full;
        logic count_one;
    } t_dp_status;

endpackage

// ----- hw/rtl/tcw_controller.sv -----
// Sequencer that decodes requests and steps the datapath through digit work and writes.
module tcw_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  tcw_pkg::t_in_item    i_in_data,
    output logic                 o_in_ready,
    input  tcw_pkg::t_dp_status  i_status,
    output tcw_pkg::t_dp_cmd     o_cmd
);

    tcw_pkg::t_state r_state;
    tcw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            tcw_pkg::ST_IDLE: begin
                // Requests are refused while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    if (i_in_data.command == tcw_pkg::CMD_INT) begin
                        o_cmd.load_item = 1'b1;
                        n_state         = tcw_pkg::ST_MUL;
                    end else if (i_in_data.char_code == tcw_pkg::NEWLINE_CODE) begin
                        o_cmd.do_newline = 1'b1;
                    end else if (i_in_data.char_code != tcw_pkg::NUL_CODE) begin
                        o_cmd.load_item = 1'b1;
                        n_state         = tcw_pkg::ST_CHAR;
                    end
                end
            end
            tcw_pkg::ST_CHAR: begin
                if (i_status.out_free) begin
                    o_cmd.load_char_out = 1'b1;
                    n_state             = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_MUL: begin
                o_cmd.do_mul = 1'b1;
                n_state      = tcw_pkg::ST_DIV;
            end
            tcw_pkg::ST_DIV: begin
                o_cmd.do_div = 1'b1;
                // Stop once the quotient runs out or the digit store is full.
                if (i_status.quot_zero || i_status.count_full) begin
                    n_state = tcw_pkg::ST_EMIT;
                end else begin
                    n_state = tcw_pkg::ST_MUL;
                end
            end
            tcw_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_digit_out = 1'b1;
                    if (i_status.count_one) begin
                        n_state = tcw_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/tcw_datapath.sv -----
// Cursor, digit extraction, digit store and output register of the text console writer.
module tcw_datapath #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int MAX_DIGITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcw_pkg::t_dp_cmd     i_cmd,
    input  tcw_pkg::t_in_item    i_in_data,
    output tcw_pkg::t_dp_status  o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tcw_pkg::t_out_item   o_out_data
);

    localparam int TOTAL     = ROWS * COLUMNS;
    localparam int CW        = $clog2(TOTAL);
    localparam int CW1       = CW + 1;
    localparam int RW        = $clog2(ROWS);
    localparam int COLW      = $clog2(COLUMNS);
    localparam int CNTW      = $clog2(MAX_DIGITS + 1);
    localparam int IW        = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int XW        = CW + tcw_pkg::CELL_W;
    localparam int PW        = tcw_pkg::NUM_W + tcw_pkg::RECIP_W;
    localparam int QW        = PW - tcw_pkg::RECIP_SHIFT;
    localparam bit START_OK  = tcw_pkg::START_CELL < TOTAL;
    localparam int START_ROW = START_OK ? tcw_pkg::START_CELL / COLUMNS : 0;
    localparam int START_COL = START_OK ? tcw_pkg::START_CELL % COLUMNS : 0;
    localparam int START_IDX = START_OK ? tcw_pkg::START_CELL : 0;

    logic [RW-1:0]   r_row;
    logic [COLW-1:0] r_col;
    logic [CW-1:0]   r_cell;
    logic [RW-1:0]   n_row;
    logic [COLW-1:0] n_col;
    logic [CW-1:0]   n_cell;

    logic [tcw_pkg::CHAR_W-1:0]  r_code;
    logic [tcw_pkg::ATTR_W-1:0]  r_attr;
    logic [tcw_pkg::NUM_W-1:0]   r_val;
    logic [PW-1:0]               r_prod;
    logic [CNTW-1:0]             r_count;
    logic [tcw_pkg::DIGIT_W-1:0] r_digits [MAX_DIGITS];

    logic                r_out_valid;
    tcw_pkg::t_out_item  r_out_data;

    logic                        w_advance;
    logic [QW-1:0]               w_quot;
    logic [tcw_pkg::NUM_W-1:0]   w_quot_ext;
    logic [tcw_pkg::NUM_W-1:0]   w_rem;
    logic [CNTW-1:0]             w_rd_count;
    logic [tcw_pkg::DIGIT_W-1:0] w_rd_digit;
    logic [XW-1:0]               w_cell_ext;

    assign w_advance = i_cmd.load_char_out || i_cmd.load_digit_out;

    // Cursor kept as row, column and linear cell so newline needs no division.
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_cell = r_cell;
        if (i_cmd.do_newline) begin
            n_col = '0;
            if (r_row == RW'(ROWS - 1)) begin
                n_row  = '0;
                n_cell = '0;
            end else begin
                n_row  = r_row + 1'b1;
                n_cell = CW'((CW1'(r_cell) - CW1'(r_col)) + CW1'(COLUMNS));
            end
        end else if (w_advance) begin
            if (r_col == COLW'(COLUMNS - 1)) begin
                n_col = '0;
                if (r_row == RW'(ROWS - 1)) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
            if (r_cell == CW'(TOTAL - 1)) begin
                n_cell = '0;
            end else begin
                n_cell = r_cell + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= RW'(START_ROW);
            r_col  <= COLW'(START_COL);
            r_cell <= CW'(START_IDX);
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_cell <= n_cell;
        end
    end

    // Divide by ten through the reciprocal product taken in the previous cycle.
    assign w_quot     = r_prod[PW-1:tcw_pkg::RECIP_SHIFT];
    assign w_quot_ext = tcw_pkg::NUM_W'(w_quot);
    assign w_rem      = r_val - ((w_quot_ext << 3) + (w_quot_ext << 1));

    assign w_rd_count = r_count - 1'b1;
    assign w_rd_digit = r_digits[w_rd_count[IW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_code <= i_in_data.char_code;
            r_attr <= i_in_data.attribute;
            r_val  <= i_in_data.number;
        end
        if (i_cmd.do_mul) begin
            r_prod <= PW'(r_val) * PW'(tcw_pkg::RECIP);
        end
        if (i_cmd.do_div) begin
            r_val                     <= w_quot_ext;
            r_digits[r_count[IW-1:0]] <= w_rem[tcw_pkg::DIGIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load_item) begin
            r_count <= '0;
        end else if (i_cmd.do_div) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.load_digit_out) begin
            r_count <= w_rd_count;
        end
    end

    assign w_cell_ext = XW'(r_cell);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char_out) begin
            r_out_data.cell_index <= w_cell_ext[tcw_pkg::CELL_W-1:0];
            r_out_data.glyph      <= r_code;
            r_out_data.colour     <= r_attr;
            r_out_data.last       <= 1'b1;
        end else if (i_cmd.load_digit_out) begin
            r_out_data.cell_index <= w_cell_ext[tcw_pkg::CELL_W-1:0];
            r_out_data.glyph      <= tcw_pkg::ZERO_GLYPH
                                     + tcw_pkg::CHAR_W'(w_rd_digit);
            r_out_data.colour     <= r_attr;
            r_out_data.last       <= (r_count == CNTW'(1));
        end
    end

    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.quot_zero  = (w_quot == '0);
    assign o_status.count_full = (r_count == CNTW'(MAX_DIGITS - 1));
    assign o_status.count_one  = (r_count == CNTW'(1));

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- hw/rtl/text_console_writer.sv -----
// Top level of the text console writer: sequencer plus datapath.
//
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_ready    i_in_data  (tcw_pkg::t_in_item)
//  out      output     o_out_valid / i_out_ready  o_out_data (tcw_pkg::t_out_item)
//
// A NUL or newline request is taken and writes nothing.
// A character request is accepted, then loaded into the output register once it is free.
// An integer is accepted, then takes one reciprocal multiply and one remainder step per
// digit, then one write per digit through the output register.
// Reset puts the cursor on cell 1140 and empties the output register.
// A stalled output holds the sequencer in its write state; no request is taken then.
module text_console_writer #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int MAX_DIGITS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tcw_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tcw_pkg::t_out_item  o_out_data
);

    tcw_pkg::t_dp_cmd     w_cmd;
    tcw_pkg::t_dp_status  w_status;

    tcw_controller u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tcw_datapath #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // A write is only loaded when the output register is free.
    a_write_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_char_out || w_cmd.load_digit_out) |-> w_status.out_free)
        else $error("output register overwritten while holding a result");

    // Every remainder step uses a product taken in the cycle before.
    a_div_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.do_div |-> $past(w_cmd.do_mul))
        else $error("digit step without a fresh reciprocal product");

    // No request is taken while an integer or a character is being worked on.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |->
            !(w_cmd.do_mul || w_cmd.do_div || w_cmd.load_digit_out || w_cmd.load_char_out))
        else $error("request accepted during integer or character work");

    // Character and digit writes never collide.
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.load_char_out && w_cmd.load_digit_out))
        else $error("two writes loaded in one cycle");

endmodule
